>>> rtl/tpc_pkg.sv
// Shared constants and types for the throttle position conditioner.
// Depends on nothing; every other file in rtl/ imports it.
`default_nettype none

package tpc_pkg;

  // Result scale: 0 full reverse, 500 neutral, 1000 full forward.
  localparam int unsigned PM_W       = 10;
  localparam int unsigned NEUTRAL    = 500;
  localparam int unsigned FULL_SCALE = 1000;

  // Defaults for the top-level parameters.
  localparam int unsigned AVERAGE_DEPTH_DEF = 16;
  localparam int unsigned SAMPLE_BITS_DEF   = 12;

  // Calibration register file.
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PORT_RMAX = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PORT_RMIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PORT_FMIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PORT_FMAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STBD_RMAX = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STBD_RMIN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STBD_FMIN = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STBD_FMAX = 3'd7;

  localparam int unsigned RMAX_RESET = 0;
  localparam int unsigned RMIN_RESET = 1900;
  localparam int unsigned FMIN_RESET = 2200;
  localparam int unsigned FMAX_RESET = 4095;

  // Commands from the sequencer to the averaging memory.
  typedef struct packed {
    logic rd;    // read the oldest ring entry
    logic push;  // replace the oldest entry and update the running sum
  } avg_cmd_t;

endpackage

`default_nettype wire

>>> rtl/tpc_div.sv
// Restoring divider that produces a 10-bit quotient, one bit per cycle.
// Uses tpc_pkg for the quotient width. The caller guarantees num < den * 1024.
`default_nettype none

module tpc_div #(
  parameter int unsigned NUM_W = 22,
  parameter int unsigned DEN_W = 12
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [NUM_W-1:0]          num,
  input  wire logic [DEN_W-1:0]          den,
  output logic                           done,
  output logic [tpc_pkg::PM_W-1:0]       quot
);
  import tpc_pkg::*;

  localparam int unsigned CNT_W = $clog2(PM_W + 1);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [PM_W-1:0]  lo_r, lo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign trial = {rem_r, lo_r[PM_W-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      // The upper part of the numerator is already below the divisor.
      rem_nxt = DEN_W'(num >> PM_W);
      lo_nxt  = num[PM_W-1:0];
      cnt_nxt = CNT_W'(PM_W);
    end else if (cnt_r != '0) begin
      rem_nxt  = ge ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
      lo_nxt   = {lo_r[PM_W-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign done = done_r;
  assign quot = lo_r;

endmodule

`default_nettype wire

>>> rtl/tpc_avg.sv
// Moving-average history: ring memory, running sum and oldest-slot pointer.
// Uses tpc_pkg for the command struct and the neutral value.
`default_nettype none

module tpc_avg #(
  parameter int unsigned AVERAGE_DEPTH = 16,
  parameter int unsigned SUM_W         = 14
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire tpc_pkg::avg_cmd_t           cmd,
  input  wire logic [tpc_pkg::PM_W-1:0]    pm,
  output logic [SUM_W-1:0]                 sum
);
  import tpc_pkg::*;

  localparam int unsigned SLOT_W = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;

  logic [PM_W-1:0]   ring_mem [0:AVERAGE_DEPTH-1];
  logic [PM_W-1:0]   rd_q;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              wrapped_r, wrapped_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [PM_W-1:0]   oldest;

  // Until the pointer has gone once around, the oldest entry is taken as
  // neutral in place of the memory contents, so the memory needs no clearing pass.
  assign oldest = wrapped_r ? rd_q : PM_W'(NEUTRAL);

  always_comb begin
    slot_nxt    = slot_r;
    wrapped_nxt = wrapped_r;
    sum_nxt     = sum_r;
    if (cmd.push) begin
      sum_nxt = sum_r - SUM_W'(oldest) + SUM_W'(pm);
      if (slot_r == SLOT_W'(AVERAGE_DEPTH - 1)) begin
        slot_nxt    = '0;
        wrapped_nxt = 1'b1;
      end else begin
        slot_nxt = slot_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r    <= '0;
      wrapped_r <= 1'b0;
      sum_r     <= SUM_W'(AVERAGE_DEPTH * NEUTRAL);
    end else begin
      slot_r    <= slot_nxt;
      wrapped_r <= wrapped_nxt;
      sum_r     <= sum_nxt;
    end
  end

  // The read is issued when a request is taken and the write-back follows in
  // the push state, after the clamp and scale steps, so a read never meets a pending write.
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_q <= ring_mem[slot_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      ring_mem[slot_r] <= pm;
    end
  end

  assign sum = sum_r;

endmodule

`default_nettype wire

>>> rtl/throttle_position_conditioner.sv
// Top level: calibration registers, clamp and scale sequencer, output register.
// Uses tpc_pkg, tpc_div and tpc_avg.
//
//   channel  dir  handshake             payload
//   in_      in   in_valid / in_ready   emergency_stop, select pins, two samples
//   out_     out  out_valid / out_ready position_per_mille, port_active
//   cfg_     in   cfg_we                cfg_index, cfg_data
//
// One request is worked on at a time: it is accepted, clamped, multiplied,
// divided by the 10-step scaling divider, pushed into the average and then
// loaded into the result register. A neutral or stopped request skips the
// divider. The mean is a multiply by the rounded-up reciprocal of the depth
// at the final load, and no new request is taken until that load is done.
// Reset is synchronous and needs no clearing pass: the ring reads as neutral
// until it has been filled once. A result still waiting on out_ready holds
// back the final load, and with it the next request.
`default_nettype none

module throttle_position_conditioner #(
  parameter int unsigned AVERAGE_DEPTH = tpc_pkg::AVERAGE_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS   = tpc_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_emergency_stop,
  input  wire logic                          in_stbd_select_pin,
  input  wire logic                          in_port_select_pin,
  input  wire logic [SAMPLE_BITS-1:0]        in_port_sample,
  input  wire logic [SAMPLE_BITS-1:0]        in_stbd_sample,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [tpc_pkg::PM_W-1:0]           out_position_per_mille,
  output logic                               out_port_active,
  input  wire logic                          cfg_we,
  input  wire logic [tpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SAMPLE_BITS-1:0]        cfg_data
);
  import tpc_pkg::*;

  localparam int unsigned PROD_W = SAMPLE_BITS + PM_W;
  localparam int unsigned SUM_W  = $clog2(AVERAGE_DEPTH * FULL_SCALE + 1);
  localparam int unsigned NUM_W  = PROD_W;
  localparam int unsigned DEN_W  = SAMPLE_BITS;

  // Exact division of the running sum by the depth: sum * ceil(2^sh / depth) >> sh.
  localparam int unsigned     MEAN_SH  = SUM_W + $clog2(AVERAGE_DEPTH);
  localparam int unsigned     MEAN_W   = 2 * SUM_W + 1;
  localparam longint unsigned MEAN_MUL =
    ((64'd1 << MEAN_SH) + 64'(AVERAGE_DEPTH) - 64'd1) / 64'(AVERAGE_DEPTH);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CLAMP = 4'd1;
  localparam logic [3:0] ST_MUL   = 4'd2;
  localparam logic [3:0] ST_DIVS  = 4'd3;
  localparam logic [3:0] ST_DIVW  = 4'd4;
  localparam logic [3:0] ST_PUSH  = 4'd5;
  localparam logic [3:0] ST_OUT   = 4'd6;

  logic [SAMPLE_BITS-1:0] cal_r [0:NUM_REGS-1];

  logic [3:0]             state_r, state_nxt;
  logic                   estop_r;
  logic                   port_r;
  logic [SAMPLE_BITS-1:0] v_r;
  logic                   neutral_r;
  logic [SAMPLE_BITS-1:0] diff_r;
  logic [SAMPLE_BITS-1:0] span_r;
  logic [PROD_W-1:0]      prod_r;
  logic [PM_W-1:0]        pm_r;
  logic                   out_valid_r;
  logic [PM_W-1:0]        out_pm_r;
  logic                   out_port_r;

  logic                   accept;
  logic [SAMPLE_BITS-1:0] rmax, rmin, fmin, fmax;
  logic [SAMPLE_BITS-1:0] vc;
  logic                   neutral_c;

  avg_cmd_t               avg_cmd;
  logic [SUM_W-1:0]       sum;
  logic [MEAN_W-1:0]      mean_prod;
  logic [PM_W-1:0]        mean_pm;
  logic                   div_start;
  logic [NUM_W-1:0]       div_num;
  logic [DEN_W-1:0]       div_den;
  logic                   div_done;
  logic [PM_W-1:0]        div_quot;
  logic                   out_load;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  assign mean_prod = MEAN_W'(sum) * MEAN_W'(MEAN_MUL);
  assign mean_pm   = PM_W'(mean_prod >> MEAN_SH);

  // Calibration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r[REG_PORT_RMAX] <= SAMPLE_BITS'(RMAX_RESET);
      cal_r[REG_PORT_RMIN] <= SAMPLE_BITS'(RMIN_RESET);
      cal_r[REG_PORT_FMIN] <= SAMPLE_BITS'(FMIN_RESET);
      cal_r[REG_PORT_FMAX] <= SAMPLE_BITS'(FMAX_RESET);
      cal_r[REG_STBD_RMAX] <= SAMPLE_BITS'(RMAX_RESET);
      cal_r[REG_STBD_RMIN] <= SAMPLE_BITS'(RMIN_RESET);
      cal_r[REG_STBD_FMIN] <= SAMPLE_BITS'(FMIN_RESET);
      cal_r[REG_STBD_FMAX] <= SAMPLE_BITS'(FMAX_RESET);
    end else if (cfg_we) begin
      cal_r[cfg_index] <= cfg_data;
    end
  end

  assign rmax = port_r ? cal_r[REG_PORT_RMAX] : cal_r[REG_STBD_RMAX];
  assign rmin = port_r ? cal_r[REG_PORT_RMIN] : cal_r[REG_STBD_RMIN];
  assign fmin = port_r ? cal_r[REG_PORT_FMIN] : cal_r[REG_STBD_FMIN];
  assign fmax = port_r ? cal_r[REG_PORT_FMAX] : cal_r[REG_STBD_FMAX];

  // A clamped reading is never tested against the neutral band.
  always_comb begin
    vc        = v_r;
    neutral_c = estop_r || (fmax <= rmax);
    if (v_r < rmax) begin
      vc = rmax;
    end else if (v_r > fmax) begin
      vc = fmax;
    end else if ((v_r > rmin) && (v_r < fmin)) begin
      neutral_c = 1'b1;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    avg_cmd.rd   = 1'b0;
    avg_cmd.push = 1'b0;
    div_start    = 1'b0;
    div_num      = NUM_W'(prod_r);
    div_den      = DEN_W'(span_r);
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          avg_cmd.rd = 1'b1;
          state_nxt  = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = neutral_r ? ST_PUSH : ST_DIVS;
      end
      ST_DIVS: begin
        div_start = 1'b1;
        state_nxt = ST_DIVW;
      end
      ST_DIVW: begin
        if (div_done) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        avg_cmd.push = 1'b1;
        state_nxt    = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      estop_r <= in_emergency_stop;
      // Port only when starboard is deselected and port is selected.
      port_r  <= in_stbd_select_pin && !in_port_select_pin;
      v_r     <= (in_stbd_select_pin && !in_port_select_pin) ? in_port_sample
                                                              : in_stbd_sample;
    end
    if (state_r == ST_CLAMP) begin
      neutral_r <= neutral_c;
      diff_r    <= vc - rmax;
      span_r    <= fmax - rmax;
    end
    if (state_r == ST_MUL) begin
      prod_r <= PROD_W'(diff_r) * PROD_W'(FULL_SCALE);
      if (neutral_r) begin
        pm_r <= PM_W'(NEUTRAL);
      end
    end
    if ((state_r == ST_DIVW) && div_done) begin
      pm_r <= div_quot;
    end
    if (out_load) begin
      out_pm_r   <= mean_pm;
      out_port_r <= port_r && !estop_r;
    end
  end

  tpc_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  tpc_avg #(
    .AVERAGE_DEPTH (AVERAGE_DEPTH),
    .SUM_W         (SUM_W)
  ) u_avg (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (avg_cmd),
    .pm    (pm_r),
    .sum   (sum)
  );

  assign out_valid              = out_valid_r;
  assign out_position_per_mille = out_pm_r;
  assign out_port_active        = out_port_r;

endmodule

`default_nettype wire
